FILE: rtl/core/csifs_pkg.sv
package csifs_pkg;

   // fixed field widths
   localparam int MAC_W    = 48;
   localparam int LEN_W    = 16;
   localparam int FREQ_W   = 13;
   localparam int SEQ_W    = 32;
   localparam int HDR_BYTES = 20;
   localparam int HDR_IDX_W = 5;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   // drop reasons
   localparam logic [1:0] DROP_MAC     = 2'd0;
   localparam logic [1:0] DROP_SHORT   = 2'd1;
   localparam logic [1:0] DROP_NO_FREQ = 2'd2;
   localparam logic [1:0] DROP_LARGE   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_NODE_ID    = 3'd0;
   localparam logic [2:0] REG_BAND_5G    = 3'd1;
   localparam logic [2:0] REG_MAC_EN     = 3'd2;
   localparam logic [2:0] REG_MAC_VALUE  = 3'd3;
   localparam logic [2:0] REG_SKIP_INVAL = 3'd4;

   // header constants
   localparam logic [31:0] FRAME_MAGIC  = 32'hC511_0001;
   localparam logic [7:0]  NUM_ANTENNAS = 8'd1;
   localparam logic [FREQ_W-1:0] FREQ_CH14    = 13'd2484;
   localparam logic [FREQ_W-1:0] FREQ_BASE_2G = 13'd2407;
   localparam logic [FREQ_W-1:0] FREQ_BASE_5G = 13'd5000;

   typedef enum logic [1:0] {
      JOB_HEADER,
      JOB_DATA,
      JOB_DROP
   } job_kind_type;

   typedef struct packed {
      logic [7:0]       node_id;
      logic             band_5g;
      logic             mac_filter_enable;
      logic [MAC_W-1:0] mac_filter_value;
      logic             skip_invalid_word;
   } cfg_type;

   typedef struct packed {
      job_kind_type      kind;
      logic [7:0]        data;      // payload byte
      logic              last;
      logic [1:0]        reason;
      logic [7:0]        node_id;
      logic [LEN_W-1:0]  nsub;
      logic [FREQ_W-1:0] freq;
      logic [SEQ_W-1:0]  seq;
      logic [7:0]        rssi;
      logic [7:0]        nf_dbm;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

FILE: rtl/core/csifs_req_if.sv
interface csifs_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [csifs_pkg::MAC_W-1:0] src_mac;
   logic [csifs_pkg::LEN_W-1:0] iq_len;
   logic [7:0]                  channel;
   logic signed [7:0]           rssi;
   logic signed [7:0]           nf_dbm;
   logic                        bad_lead_pair;
   logic [7:0]                  data_byte;

   modport source (output valid, req_type, src_mac, iq_len, channel, rssi, nf_dbm,
                   bad_lead_pair, data_byte, input ready);
   modport sink (input valid, req_type, src_mac, iq_len, channel, rssi, nf_dbm,
                 bad_lead_pair, data_byte, output ready);
endinterface

FILE: rtl/core/csifs_rsp_if.sv
interface csifs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_last;
   logic       dropped;
   logic [1:0] drop_reason;

   modport source (output valid, out_byte, frame_last, dropped, drop_reason, input ready);
   modport sink (input valid, out_byte, frame_last, dropped, drop_reason, output ready);
endinterface

FILE: rtl/core/csifs_queue.sv
module csifs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csifs_pkg::job_type  push_job,
   input  logic                pop,
   output csifs_pkg::job_type  head_job,
   output csifs_pkg::queue_stat_type stat
);

   csifs_pkg::job_type mem_ff [csifs_pkg::QUEUE_DEPTH];
   logic [csifs_pkg::QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [csifs_pkg::QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [csifs_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   // push only when room, pop only when something is held
   always_comb begin
      stat.full  = (count_ff == csifs_pkg::QUEUE_CNT_W'(csifs_pkg::QUEUE_DEPTH));
      stat.empty = (count_ff == '0);
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      head_job = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/csifs_front.sv
module csifs_front #(
   parameter int MAX_FRAME_BYTES = 532
) (
   input  logic               clock,
   input  logic               reset,
   csifs_req_if.sink          req_if,
   input  csifs_pkg::cfg_type cfg,
   input  logic               queue_full,
   output logic               push,
   output csifs_pkg::job_type push_job
);

   localparam logic [csifs_pkg::LEN_W:0] PLEN_LIMIT =
      (csifs_pkg::LEN_W+1)'(MAX_FRAME_BYTES - csifs_pkg::HDR_BYTES);

   logic [csifs_pkg::SEQ_W-1:0] seq_ff, seq_in;
   logic [csifs_pkg::LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic [1:0]                  skip_left_ff, skip_left_in;
   logic                        open_ff, open_in;

   logic                        accept;
   logic                        skip_take;
   logic                        too_short;
   logic                        too_large;
   logic                        mac_miss;
   logic [csifs_pkg::LEN_W-1:0] plen;
   logic [csifs_pkg::FREQ_W-1:0] freq;
   logic [csifs_pkg::FREQ_W-1:0] ch_x5;
   logic                        freq_ok;
   logic                        is_last;

   assign req_if.ready = !queue_full;
   assign accept = req_if.valid && req_if.ready;

   // start checks
   always_comb begin
      mac_miss  = cfg.mac_filter_enable && (req_if.src_mac != cfg.mac_filter_value);
      skip_take = cfg.skip_invalid_word && req_if.bad_lead_pair &&
                  (req_if.iq_len > 16'd2);
      too_short = skip_take ? (req_if.iq_len < 16'd4) : (req_if.iq_len < 16'd2);
      plen      = skip_take ? req_if.iq_len - 16'd2 : req_if.iq_len;
      too_large = ({1'b0, plen} > PLEN_LIMIT);
   end

   // centre frequency from band and channel
   always_comb begin
      ch_x5   = {3'b000, req_if.channel, 2'b00} + {5'b00000, req_if.channel};
      freq    = '0;
      freq_ok = 1'b0;
      if (cfg.band_5g) begin
         if (req_if.channel inside {[8'd36:8'd177]}) begin
            freq    = csifs_pkg::FREQ_BASE_5G + ch_x5;
            freq_ok = 1'b1;
         end
      end else if (req_if.channel inside {[8'd1:8'd13]}) begin
         freq    = csifs_pkg::FREQ_BASE_2G + ch_x5;
         freq_ok = 1'b1;
      end else if (req_if.channel == 8'd14) begin
         freq    = csifs_pkg::FREQ_CH14;
         freq_ok = 1'b1;
      end
   end

   // classify the item, build the job and the next frame state
   always_comb begin
      seq_in        = seq_ff;
      bytes_left_in = bytes_left_ff;
      skip_left_in  = skip_left_ff;
      open_in       = open_ff;
      push          = 1'b0;
      is_last       = (bytes_left_ff == 16'd1);

      push_job             = '0;
      push_job.kind        = csifs_pkg::JOB_DATA;
      push_job.data        = req_if.data_byte;
      push_job.node_id     = cfg.node_id;
      push_job.nsub        = {1'b0, plen[csifs_pkg::LEN_W-1:1]};
      push_job.freq        = freq;
      push_job.seq         = seq_ff;
      push_job.rssi        = req_if.rssi;
      push_job.nf_dbm      = req_if.nf_dbm;

      if (accept) begin
         if (req_if.req_type == csifs_pkg::REQ_START) begin
            open_in       = 1'b0;
            bytes_left_in = '0;
            skip_left_in  = '0;
            push          = 1'b1;
            push_job.kind = csifs_pkg::JOB_DROP;
            push_job.last = 1'b1;
            if (mac_miss) begin
               push_job.reason = csifs_pkg::DROP_MAC;
            end else if (too_short) begin
               push_job.reason = csifs_pkg::DROP_SHORT;
            end else if (too_large) begin
               push_job.reason = csifs_pkg::DROP_LARGE;
            end else if (!freq_ok) begin
               push_job.reason = csifs_pkg::DROP_NO_FREQ;
            end else begin
               push_job.kind = csifs_pkg::JOB_HEADER;
               push_job.last = 1'b0;
               seq_in        = seq_ff + 1'b1;
               open_in       = 1'b1;
               bytes_left_in = plen;
               skip_left_in  = skip_take ? 2'd2 : 2'd0;
            end
         end else if (open_ff) begin
            if (skip_left_ff != '0) begin
               skip_left_in = skip_left_ff - 1'b1;
            end else begin
               push          = 1'b1;
               push_job.last = is_last;
               bytes_left_in = bytes_left_ff - 1'b1;
               if (is_last) begin
                  open_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= '0;
         bytes_left_ff <= '0;
         skip_left_ff  <= '0;
         open_ff       <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         bytes_left_ff <= bytes_left_in;
         skip_left_ff  <= skip_left_in;
         open_ff       <= open_in;
      end
   end

endmodule

FILE: rtl/core/csifs_back.sv
module csifs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  csifs_pkg::job_type         head_job,
   input  csifs_pkg::queue_stat_type  stat,
   output logic                       pop,
   csifs_rsp_if.source                rsp_if
);

   logic [csifs_pkg::HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       drop_ff, drop_in;
   logic [1:0] reason_ff, reason_in;
   logic       load;
   logic       hdr_end;
   logic [7:0] hdr_byte;

   // header byte select, little-endian fields
   always_comb begin
      case (hdr_idx_ff)
         5'd0:    hdr_byte = csifs_pkg::FRAME_MAGIC[7:0];
         5'd1:    hdr_byte = csifs_pkg::FRAME_MAGIC[15:8];
         5'd2:    hdr_byte = csifs_pkg::FRAME_MAGIC[23:16];
         5'd3:    hdr_byte = csifs_pkg::FRAME_MAGIC[31:24];
         5'd4:    hdr_byte = head_job.node_id;
         5'd5:    hdr_byte = csifs_pkg::NUM_ANTENNAS;
         5'd6:    hdr_byte = head_job.nsub[7:0];
         5'd7:    hdr_byte = head_job.nsub[15:8];
         5'd8:    hdr_byte = head_job.freq[7:0];
         5'd9:    hdr_byte = {3'b000, head_job.freq[csifs_pkg::FREQ_W-1:8]};
         5'd12:   hdr_byte = head_job.seq[7:0];
         5'd13:   hdr_byte = head_job.seq[15:8];
         5'd14:   hdr_byte = head_job.seq[23:16];
         5'd15:   hdr_byte = head_job.seq[31:24];
         5'd16:   hdr_byte = head_job.rssi;
         5'd17:   hdr_byte = head_job.nf_dbm;
         default: hdr_byte = 8'h00;
      endcase
   end

   // output register refills from the queue head whenever it is empty or being taken and the queue holds a job
   always_comb begin
      load      = !stat.empty && (!valid_ff || rsp_if.ready);
      hdr_end   = (hdr_idx_ff == csifs_pkg::HDR_IDX_W'(csifs_pkg::HDR_BYTES - 1));
      pop       = 1'b0;
      hdr_idx_in = hdr_idx_ff;
      valid_in  = valid_ff && !rsp_if.ready;
      byte_in   = byte_ff;
      last_in   = last_ff;
      drop_in   = drop_ff;
      reason_in = reason_ff;
      if (load) begin
         valid_in  = 1'b1;
         last_in   = head_job.last;
         drop_in   = 1'b0;
         reason_in = csifs_pkg::DROP_MAC;
         case (head_job.kind)
            csifs_pkg::JOB_HEADER: begin
               byte_in    = hdr_byte;
               pop        = hdr_end;
               hdr_idx_in = hdr_end ? '0 : hdr_idx_ff + 1'b1;
            end
            csifs_pkg::JOB_DROP: begin
               byte_in   = 8'h00;
               drop_in   = 1'b1;
               reason_in = head_job.reason;
               pop       = 1'b1;
            end
            default: begin
               byte_in = head_job.data;
               pop     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         hdr_idx_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         hdr_idx_ff <= hdr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      drop_ff   <= drop_in;
      reason_ff <= reason_in;
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.out_byte    = byte_ff;
   assign rsp_if.frame_last  = last_ff;
   assign rsp_if.dropped     = drop_ff;
   assign rsp_if.drop_reason = reason_ff;

endmodule

FILE: rtl/core/csi_frame_serializer_unit.sv
// Channel   Dir  Handshake        Carries
// req_if    in   valid/ready      start descriptor or one I/Q data byte
// rsp_if    out  valid/ready      header byte, payload byte or drop report
// csr_*     in   APB, pready = 1  node id, band, MAC filter, skip control
//
// A data item gives at most one byte. A start item's twenty header bytes leave
// the back end one per cycle while rsp_if.ready is high, so the output port sets
// the sustained rate. A four-entry job queue lets the front keep taking items
// while header bytes drain; req_if.ready drops only when that queue is full.
// Reset is synchronous and clears sequence, frame state, queue and output valid;
// no clearing pass is needed.
module csi_frame_serializer_unit #(
   parameter int MAX_FRAME_BYTES = 532
) (
   input  logic        clock,
   input  logic        reset,
   csifs_req_if.sink   req_if,
   csifs_rsp_if.source rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   csifs_pkg::cfg_type        cfg_ff, cfg_in;
   csifs_pkg::job_type        push_job, head_job;
   csifs_pkg::queue_stat_type stat;
   logic       push, pop;
   logic       wr_en;
   logic [2:0] reg_idx;

   // register file
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            csifs_pkg::REG_NODE_ID:    cfg_in.node_id = csr_pwdata[7:0];
            csifs_pkg::REG_BAND_5G:    cfg_in.band_5g = csr_pwdata[0];
            csifs_pkg::REG_MAC_EN:     cfg_in.mac_filter_enable = csr_pwdata[0];
            csifs_pkg::REG_MAC_VALUE:
               cfg_in.mac_filter_value = csr_pwdata[csifs_pkg::MAC_W-1:0];
            csifs_pkg::REG_SKIP_INVAL: cfg_in.skip_invalid_word = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         csifs_pkg::REG_NODE_ID:    csr_prdata = {56'd0, cfg_ff.node_id};
         csifs_pkg::REG_BAND_5G:    csr_prdata = {63'd0, cfg_ff.band_5g};
         csifs_pkg::REG_MAC_EN:     csr_prdata = {63'd0, cfg_ff.mac_filter_enable};
         csifs_pkg::REG_MAC_VALUE:  csr_prdata = {16'd0, cfg_ff.mac_filter_value};
         csifs_pkg::REG_SKIP_INVAL: csr_prdata = {63'd0, cfg_ff.skip_invalid_word};
         default:                   csr_prdata = 64'd0;
      endcase
   end

   // skip control comes out of reset enabled, everything else cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{node_id: 8'd0, band_5g: 1'b0, mac_filter_enable: 1'b0,
                     mac_filter_value: '0, skip_invalid_word: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csifs_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .queue_full (stat.full),
      .push       (push),
      .push_job   (push_job)
   );

   csifs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (stat)
   );

   csifs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .stat     (stat),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

FILE: sim/tb_top.sv
module tb_top;

   localparam int FRAME_MAX      = 532;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 200;
   localparam logic [1:0] NO_REASON = 2'd0;

   // one accepted input item as seen on the request channel
   typedef struct {
      logic                        kind;
      logic [csifs_pkg::MAC_W-1:0] mac;
      logic [csifs_pkg::LEN_W-1:0] iq_len;
      logic [7:0]                  channel;
      logic [7:0]                  rssi;
      logic [7:0]                  nf_dbm;
      logic                        fwi;
      logic [7:0]                  data_byte;
   } capture_item_type;

   // one serialized byte or drop report
   typedef struct {
      logic [7:0] out_byte;
      logic       frame_last;
      logic       dropped;
      logic [1:0] drop_reason;
   } serial_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   csifs_req_if req_if ();
   csifs_rsp_if rsp_if ();

   csi_frame_serializer_unit #(
      .MAX_FRAME_BYTES(FRAME_MAX)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // shadow of the block: registers and framing state
   csifs_pkg::cfg_type                model_cfg;
   logic [csifs_pkg::SEQ_W-1:0] seq_no;
   logic [csifs_pkg::LEN_W-1:0] payload_left;
   logic [1:0]                  skip_pending;
   logic                        frame_active;

   serial_byte_type due_bytes[$];
   int mismatches    = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;

   function automatic logic [csifs_pkg::FREQ_W-1:0] lookup_freq(input logic [7:0] ch);
      if (model_cfg.band_5g) begin
         if (ch >= 36 && ch <= 177)
            return csifs_pkg::FREQ_W'(csifs_pkg::FREQ_BASE_5G + ch * 5);
         return '0;
      end
      if (ch >= 1 && ch <= 13)
         return csifs_pkg::FREQ_W'(csifs_pkg::FREQ_BASE_2G + ch * 5);
      if (ch == 14) return csifs_pkg::FREQ_CH14;
      return '0;
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic last,
                                     input logic drop, input logic [1:0] why);
      serial_byte_type sb;
      sb.out_byte    = b;
      sb.frame_last  = last;
      sb.dropped     = drop;
      sb.drop_reason = why;
      due_bytes.push_back(sb);
   endfunction

   // work out the bytes one accepted item causes
   function automatic void predict_serial(input capture_item_type it);
      int unsigned skip;
      int unsigned plen;
      logic [csifs_pkg::FREQ_W-1:0] freq;
      logic [csifs_pkg::LEN_W-1:0]  nsub;
      logic [159:0]                 hdr;
      if (it.kind == csifs_pkg::REQ_DATA) begin
         if (!frame_active) return;
         if (skip_pending != 0) begin
            skip_pending = skip_pending - 1'b1;
            return;
         end
         payload_left = payload_left - 1'b1;
         push_byte(it.data_byte, payload_left == 0, 1'b0, NO_REASON);
         if (payload_left == 0) frame_active = 1'b0;
         return;
      end
      // a new start silently abandons any open frame
      frame_active = 1'b0;
      payload_left = '0;
      skip_pending = '0;
      skip = (model_cfg.skip_invalid_word && it.fwi && it.iq_len > 2) ? 2 : 0;
      plen = it.iq_len - skip;
      freq = lookup_freq(it.channel);
      if (model_cfg.mac_filter_enable && it.mac != model_cfg.mac_filter_value)
         push_byte(8'd0, 1'b1, 1'b1, csifs_pkg::DROP_MAC);
      else if (it.iq_len < skip + 2)
         push_byte(8'd0, 1'b1, 1'b1, csifs_pkg::DROP_SHORT);
      else if (csifs_pkg::HDR_BYTES + plen > FRAME_MAX)
         push_byte(8'd0, 1'b1, 1'b1, csifs_pkg::DROP_LARGE);
      else if (freq == 0)
         push_byte(8'd0, 1'b1, 1'b1, csifs_pkg::DROP_NO_FREQ);
      else begin
         nsub = csifs_pkg::LEN_W'(plen / 2);
         hdr = {16'd0, it.nf_dbm, it.rssi, seq_no, 32'(freq), nsub,
                csifs_pkg::NUM_ANTENNAS, model_cfg.node_id, csifs_pkg::FRAME_MAGIC};
         for (int i = 0; i < csifs_pkg::HDR_BYTES; i++)
            push_byte(hdr[8*i +: 8], 1'b0, 1'b0, NO_REASON);
         seq_no       = seq_no + 1'b1;
         frame_active = 1'b1;
         payload_left = csifs_pkg::LEN_W'(plen);
         skip_pending = 2'(skip);
      end
   endfunction

   // predict on accepted input, then check accepted output against the oldest byte due
   always @(posedge clock) begin
      capture_item_type it;
      serial_byte_type  want;
      if (!reset && req_if.valid && req_if.ready) begin
         it.kind        = req_if.req_type;
         it.mac         = req_if.src_mac;
         it.iq_len      = req_if.iq_len;
         it.channel     = req_if.channel;
         it.rssi        = req_if.rssi;
         it.nf_dbm      = req_if.nf_dbm;
         it.fwi         = req_if.bad_lead_pair;
         it.data_byte   = req_if.data_byte;
         predict_serial(it);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_bytes.size() == 0) begin
            $error("unexpected result: out_byte %0h dropped %0b", rsp_if.out_byte,
                   rsp_if.dropped);
            mismatches++;
         end else begin
            want = due_bytes.pop_front();
            if (rsp_if.out_byte !== want.out_byte) begin
               $error("out_byte expected %0h got %0h", want.out_byte, rsp_if.out_byte);
               mismatches++;
            end
            if (rsp_if.frame_last !== want.frame_last) begin
               $error("frame_last expected %0b got %0b", want.frame_last, rsp_if.frame_last);
               mismatches++;
            end
            if (rsp_if.dropped !== want.dropped) begin
               $error("dropped expected %0b got %0b", want.dropped, rsp_if.dropped);
               mismatches++;
            end
            if (rsp_if.drop_reason !== want.drop_reason) begin
               $error("drop_reason expected %0d got %0d", want.drop_reason,
                      rsp_if.drop_reason);
               mismatches++;
            end
         end
      end
   end

   // result side: random stalls plus an optional long hold-off
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || csr_psel || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic logic [csifs_pkg::MAC_W-1:0] random_mac();
      return csifs_pkg::MAC_W'({$urandom, $urandom});
   endfunction

   function automatic capture_item_type start_item(input logic [csifs_pkg::MAC_W-1:0] mac,
         input int unsigned len, input int unsigned ch, input logic [7:0] rssi,
         input logic [7:0] nf, input logic fwi);
      capture_item_type it;
      it.kind        = csifs_pkg::REQ_START;
      it.mac         = mac;
      it.iq_len      = csifs_pkg::LEN_W'(len);
      it.channel     = 8'(ch);
      it.rssi        = rssi;
      it.nf_dbm      = nf;
      it.fwi         = fwi;
      it.data_byte   = 8'($urandom);
      return it;
   endfunction

   function automatic logic [7:0] pick_channel(input logic mapped);
      if (!mapped) return 8'($urandom_range(0, 255));
      if (model_cfg.band_5g) return 8'($urandom_range(36, 177));
      return 8'($urandom_range(1, 14));
   endfunction

   // offer one item, with a random gap first; valid stays high on return
   task automatic send_item(input capture_item_type it);
      int gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid              <= 1'b1;
      req_if.req_type           <= it.kind;
      req_if.src_mac            <= it.mac;
      req_if.iq_len             <= it.iq_len;
      req_if.channel            <= it.channel;
      req_if.rssi               <= it.rssi;
      req_if.nf_dbm             <= it.nf_dbm;
      req_if.bad_lead_pair      <= it.fwi;
      req_if.data_byte          <= it.data_byte;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // data items carry random junk in the start fields
   task automatic send_payload(input int count);
      capture_item_type it;
      repeat (count) begin
         it = start_item(random_mac(), $urandom_range(0, 65535), $urandom_range(0, 255),
                         8'($urandom), 8'($urandom), 1'($urandom));
         it.kind = csifs_pkg::REQ_DATA;
         send_item(it);
      end
   endtask

   // stop sending, let every due byte arrive, then let the block go quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (due_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         csifs_pkg::REG_NODE_ID:    model_cfg.node_id           = value[7:0];
         csifs_pkg::REG_BAND_5G:    model_cfg.band_5g           = value[0];
         csifs_pkg::REG_MAC_EN:     model_cfg.mac_filter_enable = value[0];
         csifs_pkg::REG_MAC_VALUE:
            model_cfg.mac_filter_value = value[csifs_pkg::MAC_W-1:0];
         csifs_pkg::REG_SKIP_INVAL: model_cfg.skip_invalid_word = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_regs(input logic [7:0] node, input logic band,
         input logic mac_en, input logic [csifs_pkg::MAC_W-1:0] mac, input logic skip);
      write_reg(csifs_pkg::REG_NODE_ID, 64'(node));
      write_reg(csifs_pkg::REG_BAND_5G, 64'(band));
      write_reg(csifs_pkg::REG_MAC_EN, 64'(mac_en));
      write_reg(csifs_pkg::REG_MAC_VALUE, 64'(mac));
      write_reg(csifs_pkg::REG_SKIP_INVAL, 64'(skip));
   endtask

   // length limits, skip rule and field extremes under reset settings
   task automatic test_length_edges();
      send_item(start_item(random_mac(), 0, 1, 8'd0, 8'd0, 1'b0));
      send_item(start_item(random_mac(), 1, 1, 8'd0, 8'd0, 1'b1));
      // skip not taken when only one pair is present
      send_item(start_item('0, 2, 1, 8'h80, 8'h7F, 1'b1));
      send_item(start_item('1, 1, 1, 8'h00, 8'h00, 1'b0));
      send_payload(2);
      // three bytes with a corrupt leading pair: dropped as too short once the pair is skipped
      send_item(start_item(random_mac(), 3, 14, 8'h7F, 8'h80, 1'b1));
      send_payload(3);
      // largest payload that fits, then abandoned by the next start
      send_item(start_item(random_mac(), FRAME_MAX - csifs_pkg::HDR_BYTES + 2, 13,
                           8'hFF, 8'h01, 1'b1));
      send_item(start_item(random_mac(), FRAME_MAX - csifs_pkg::HDR_BYTES + 3, 13,
                           8'h01, 8'hFF, 1'b1));
      send_item(start_item(random_mac(), 65535, 0, 8'd0, 8'd0, 1'b0));
      // data with no open frame is ignored
      send_payload(1);
      settle();
   endtask

   // channel mapping on both bands
   task automatic test_channels();
      send_item(start_item(random_mac(), 4, 0, 8'd0, 8'd0, 1'b0));
      send_item(start_item(random_mac(), 4, 15, 8'd0, 8'd0, 1'b0));
      send_item(start_item(random_mac(), 4, 255, 8'd0, 8'd0, 1'b0));
      settle();
      write_reg(csifs_pkg::REG_BAND_5G, 64'd1);
      send_item(start_item(random_mac(), 2, 35, 8'd0, 8'd0, 1'b0));
      send_item(start_item(random_mac(), 2, 36, 8'hC0, 8'hA0, 1'b0));
      send_payload(2);
      send_item(start_item(random_mac(), 2, 177, 8'hC0, 8'hA0, 1'b0));
      send_item(start_item(random_mac(), 2, 178, 8'hC0, 8'hA0, 1'b0));
      send_item(start_item(random_mac(), 2, 14, 8'hC0, 8'hA0, 1'b0));
      settle();
   endtask

   // MAC filter and the order of the drop checks
   task automatic test_mac_filter();
      write_all_regs(8'hFF, 1'b1, 1'b1, '1, 1'b0);
      // skip disabled: the flagged pair passes through
      send_item(start_item('1, 3, 36, 8'd0, 8'd0, 1'b1));
      send_payload(3);
      send_item(start_item(48'h1, 0, 0, 8'd0, 8'd0, 1'b0));
      send_item(start_item('1, 0, 0, 8'd0, 8'd0, 1'b0));
      send_item(start_item('1, 600, 0, 8'd0, 8'd0, 1'b0));
      send_item(start_item('1, 4, 0, 8'd0, 8'd0, 1'b0));
      settle();
   endtask

   // hold the result side off while starts keep coming, filling the job queue
   task automatic test_backpressure();
      write_all_regs(8'h5A, 1'b0, 1'b0, '0, 1'b1);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = HOLD_CYCLES;
      repeat (8) begin
         send_item(start_item(random_mac(), 2, 6, 8'($urandom), 8'($urandom), 1'b0));
         send_payload(2);
      end
      settle();
   endtask

   task automatic run_random_phase(input int idle_p, input int stall_p, input int goal);
      int pick;
      int unsigned len;
      logic [csifs_pkg::MAC_W-1:0] mac;
      send_idle_pct = idle_p;
      stall_pct     = stall_p;
      items_sent    = 0;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // mostly well-formed frame with random content
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 24);
            mac = (model_cfg.mac_filter_enable && $urandom_range(0, 99) < 85) ?
                  model_cfg.mac_filter_value : random_mac();
            send_item(start_item(mac, len, pick_channel($urandom_range(0, 9) != 0),
                                 8'($urandom), 8'($urandom), 1'($urandom)));
            send_payload(len);
         end else if (pick < 85) begin
            // arbitrary start, usually cut short
            send_item(start_item(random_mac(), $urandom_range(0, 65535),
                                 $urandom_range(0, 255), 8'($urandom), 8'($urandom),
                                 1'($urandom)));
            send_payload($urandom_range(0, 5));
         end else begin
            send_payload($urandom_range(1, 3));
         end
      end
      settle();
   endtask

   task automatic test_random();
      write_all_regs(8'hFF, 1'b0, 1'b0, random_mac(), 1'b1);
      run_random_phase(0, 0, 20);
      write_all_regs(8'h00, 1'b1, 1'b1, '1, 1'b1);
      run_random_phase(61, 0, 20);
      write_all_regs(8'($urandom), 1'b0, 1'b1, '0, 1'b0);
      run_random_phase(0, 61, 20);
      write_all_regs(8'($urandom), 1'b1, 1'b0, random_mac(), 1'b1);
      run_random_phase(31, 31, 20);
   endtask

   initial begin
      reset                     <= 1'b1;
      req_if.valid              <= 1'b0;
      req_if.req_type           <= csifs_pkg::REQ_START;
      req_if.src_mac            <= '0;
      req_if.iq_len             <= '0;
      req_if.channel            <= '0;
      req_if.rssi               <= '0;
      req_if.nf_dbm             <= '0;
      req_if.bad_lead_pair      <= 1'b0;
      req_if.data_byte          <= '0;
      csr_psel                  <= 1'b0;
      csr_penable               <= 1'b0;
      csr_pwrite                <= 1'b0;
      csr_paddr                 <= '0;
      csr_pwdata                <= '0;
      model_cfg    = '{node_id: 8'd0, band_5g: 1'b0, mac_filter_enable: 1'b0,
                       mac_filter_value: '0, skip_invalid_word: 1'b1};
      seq_no       = '0;
      payload_left = '0;
      skip_pending = '0;
      frame_active = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_length_edges();
      test_channels();
      test_mac_filter();
      test_backpressure();
      test_random();

      settle();
      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
